### src/bda_pkg.sv
// shared types, constants and helpers of the decimal ascii renderer
package bda_pkg;

   localparam int VALUE_PORT_WIDTH    = 64;
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int MAX_DIGITS          = 20;
   localparam int DIGIT_IDX_WIDTH     = 5;
   localparam int COUNT_WIDTH         = 5;
   localparam int CHAR_WIDTH          = 6;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

   // packed bcd register, digit 0 is the least significant
   typedef logic [MAX_DIGITS-1:0][3:0] bcd_type;

   // glyph of one decimal digit
   function automatic logic [CHAR_WIDTH-1:0] digit_glyph(input logic [3:0] digit);
      digit_glyph = ASCII_ZERO + {{(CHAR_WIDTH-4){1'b0}}, digit};
   endfunction

endpackage

### src/bda_dabble_unit.sv
// one shift-and-add-3 step of the binary to bcd conversion
module bda_dabble_unit (
   input  bda_pkg::bcd_type bcd,
   input  logic             bit_in,
   output bda_pkg::bcd_type bcd_next
);

   bda_pkg::bcd_type                   adjusted;
   logic [bda_pkg::MAX_DIGITS*4-1:0]   adjusted_flat;

   // digits of five or more get three added before the shift
   always_comb begin
      for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
         adjusted[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
      end
   end

   assign adjusted_flat = adjusted;

   // whole register moves up one bit, the top bit is always clear for a 64-bit value
   assign bcd_next = {adjusted_flat[bda_pkg::MAX_DIGITS*4-2:0], bit_in};

endmodule

### src/bda_digit_count.sv
// number of significant decimal digits held in a bcd register
module bda_digit_count (
   input  bda_pkg::bcd_type                      bcd,
   output logic [bda_pkg::COUNT_WIDTH-1:0]       count
);

   // highest nonzero digit wins, zero still has one digit
   always_comb begin
      count = bda_pkg::COUNT_WIDTH'(1);
      for (int i = 1; i < bda_pkg::MAX_DIGITS; i++) begin
         if (bcd[i] != 4'd0) begin
            count = bda_pkg::COUNT_WIDTH'(i + 1);
         end
      end
   end

endmodule

### src/binary_to_decimal_ascii_core.sv
// top level of the unsigned binary to decimal ascii renderer
//
//  channel | ports                                   | beat
//  --------+-----------------------------------------+------------------------------------
//  req     | req_valid, req_ready, req_value         | one unsigned value to render
//  rsp     | rsp_valid, rsp_ready, rsp_digit_char,   | one ascii digit, most significant
//          | rsp_digit_count, rsp_last               | first, last set on the final digit
//
// a value runs through the shared double-dabble step (one bit a cycle), then the digit
// count is measured and the leading digit is loaded as the first beat, then one digit
// beat follows per rsp handshake until the last, after which the block returns to idle
// req_ready is high only while idle; a stalled rsp beat simply holds in its register
// reset is synchronous and returns the block to idle with no beat pending
module binary_to_decimal_ascii_core #(
   parameter int VALUE_WIDTH = bda_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bda_pkg::VALUE_PORT_WIDTH-1:0]  req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bda_pkg::CHAR_WIDTH-1:0]        rsp_digit_char,
   output logic [bda_pkg::COUNT_WIDTH-1:0]       rsp_digit_count,
   output logic                                  rsp_last
);

   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);

   typedef enum logic [1:0] {
      IDLE,
      CONVERT,
      MEASURE,
      EMIT
   } state_type;

   state_type                             state_ff, state_in;
   logic [VALUE_WIDTH-1:0]                bin_ff, bin_in;
   logic [BIT_CNT_WIDTH-1:0]              bit_cnt_ff, bit_cnt_in;
   bda_pkg::bcd_type                      bcd_ff, bcd_in;
   logic [bda_pkg::DIGIT_IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [bda_pkg::CHAR_WIDTH-1:0]        rsp_char_ff, rsp_char_in;
   logic [bda_pkg::COUNT_WIDTH-1:0]       rsp_count_ff, rsp_count_in;
   logic                                  rsp_last_ff, rsp_last_in;

   bda_pkg::bcd_type                      bcd_step;
   logic [bda_pkg::COUNT_WIDTH-1:0]       measured_count;
   logic [bda_pkg::DIGIT_IDX_WIDTH-1:0]   sel_idx;
   logic [3:0]                            sel_digit;

   // shared conversion step: adjust every digit, shift in the next value bit
   bda_dabble_unit u_dabble (
      .bcd      (bcd_ff),
      .bit_in   (bin_ff[VALUE_WIDTH-1]),
      .bcd_next (bcd_step)
   );

   bda_digit_count u_count (
      .bcd   (bcd_ff),
      .count (measured_count)
   );

   // digit picked for the next beat: the leading one after measuring, else one lower
   assign sel_idx   = (state_ff == MEASURE) ?
                      bda_pkg::DIGIT_IDX_WIDTH'(measured_count - 1'b1) :
                      idx_ff - 1'b1;
   assign sel_digit = bcd_ff[sel_idx];

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bit_cnt_in   = bit_cnt_ff;
      bcd_in       = bcd_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               // bits above the configured width are dropped here
               bin_in     = req_value[VALUE_WIDTH-1:0];
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
               state_in   = CONVERT;
            end
         end
         CONVERT: begin
            bcd_in = bcd_step;
            bin_in = bin_ff << 1;
            if (bit_cnt_ff == '0) begin
               state_in = MEASURE;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         MEASURE: begin
            // first beat: leading digit, count known for the whole run
            idx_in       = sel_idx;
            rsp_char_in  = bda_pkg::digit_glyph(sel_digit);
            rsp_count_in = measured_count;
            rsp_last_in  = (sel_idx == '0);
            rsp_valid_in = 1'b1;
            state_in     = EMIT;
         end
         EMIT: begin
            if (rsp_ready) begin
               if (rsp_last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = IDLE;
               end else begin
                  idx_in      = sel_idx;
                  rsp_char_in = bda_pkg::digit_glyph(sel_digit);
                  rsp_last_in = (sel_idx == '0);
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff       <= bin_in;
      bit_cnt_ff   <= bit_cnt_in;
      bcd_ff       <= bcd_in;
      idx_ff       <= idx_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready       = (state_ff == IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit_char  = rsp_char_ff;
   assign rsp_digit_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // no new value is taken while a digit beat is pending
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && req_ready))
      else $error("input taken while digits pending");

   // every beat carries a decimal glyph and a sane count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= 6'd48) && (rsp_digit_char <= 6'd57) &&
                    (rsp_digit_count != 5'd0) && (rsp_digit_count <= 5'd20))
      else $error("bad digit beat");

   // a run does not stop before its last digit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("digit run cut short");

   // the last digit frees the block for the next value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("block not idle after last digit");

endmodule
